@@ src/sensor_frame_deframer_decoder_defines.svh @@
// Assertion macros shared by the deframer/decoder modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SENSOR_FRAME_DEFRAMER_DECODER_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SFDD_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define SFDD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SFDD_ASSERT_IMPLY(label, pre, post, msg)
`define SFDD_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

@@ src/sfdd_pkg.sv @@
package sfdd_pkg;

    // Frame marker and frame type codes
    localparam logic [7:0] HDR_BYTE   = 8'h5A;
    localparam logic [7:0] TYPE_LIGHT = 8'h15;
    localparam logic [7:0] TYPE_ENV   = 8'h45;

    // Reading kinds carried on tuser
    localparam logic KIND_LIGHT = 1'b0;
    localparam logic KIND_ENV   = 1'b1;

    // Payload positions the decode looks at
    localparam int DECODE_BYTES = 10;

    // Job queue depth between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Divide by 100 as (x * magic) >> 37, exact for every 32-bit x
    localparam int          MAGIC_W      = 31;
    localparam int          RAW_W        = 32;
    localparam int          PROD_W       = RAW_W + MAGIC_W;
    localparam int          DIV100_SHIFT = 37;
    localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 31'h51EB851F;

    // Output field widths
    localparam int LUX_W   = 32;
    localparam int SMALL_W = 10;
    localparam int PRESS_W = 26;

    // Decoded frame handed from front to back
    typedef struct packed {
        logic        kind;
        logic [31:0] word;   // lux (light) or raw pressure (environment)
        logic [15:0] temp;
        logic [15:0] hum;
        logic [15:0] alt;
    } job_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

@@ src/sensor_frame_deframer_decoder.sv @@
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata[7:0] = rx_byte
// m_*      | out | m_tvalid/m_tready  | m_tuser = reading_kind, m_tdata = decoded reading
//
// One received byte is taken per cycle while the job queue has room.
// The back end runs all divisions by 100 through one 32x31 multiplier:
// an environment frame divides temperature, pressure, humidity and altitude in turn.
// The shortest frame is 5 bytes, so a two-entry queue keeps the input at full rate.
// Reset (rst_n low, asynchronous) returns to header hunt and clears the payload store.
// m_tready low holds the output word; once the queue fills, s_tready drops.
module sensor_frame_deframer_decoder
    import sfdd_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [31:0] lux_hundredths, [41:32] temperature_whole,
                                   // [67:42] pressure_whole, [77:68] humidity_whole,
                                   // [87:78] altitude_whole
    output logic        m_tuser    // [0] reading_kind
);

    job_t   push_job, head_job;
    logic   job_push, job_pop;
    qstat_t qstat;

    // Deframe received words into jobs
    sfdd_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .byte_data  (s_tdata),
        .qstat      (qstat),
        .job_push   (job_push),
        .job        (push_job)
    );

    // Decouple front and back
    sfdd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // Scale readings and drive the output word
    sfdd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_job  (head_job),
        .job_pop   (job_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata)
    );

endmodule

@@ src/sfdd_front.sv @@
module sfdd_front
    import sfdd_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 10
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] byte_data,
    input  qstat_t     qstat,
    output logic       job_push,
    output job_t       job
);

`include "sensor_frame_deframer_decoder_defines.svh"

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  index_reg, index_next;
    logic [7:0]  remain_dec;
    logic        store_wr;
    logic        accept;
    logic [7:0]  store_reg [PAYLOAD_BYTES];
    logic [7:0]  frame_byte [DECODE_BYTES];

    assign byte_ready = !qstat.full;
    assign accept     = byte_valid && byte_ready;
    assign remain_dec = (remain_reg != 8'd0) ? remain_reg - 8'd1 : 8'd0;

    // Advance the frame phase on each accepted word
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        remain_next = remain_reg;
        index_next  = index_reg;
        store_wr    = 1'b0;
        job_push    = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    phase_next = (byte_data == HDR_BYTE) ? PH_TYPE : PH_HDR1;
                end
                PH_TYPE:
                begin
                    type_next  = byte_data;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    remain_next = byte_data;
                    index_next  = 8'd0;
                    phase_next  = (byte_data == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    store_wr    = 1'b1;
                    index_next  = (index_reg != 8'hFF) ? index_reg + 8'd1 : index_reg;
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HDR1;
                    job_push   = (type_reg == TYPE_LIGHT) || (type_reg == TYPE_ENV);
                end
                default:
                begin
                    phase_next = (byte_data == HDR_BYTE) ? PH_HDR2 : PH_HDR1;
                end
            endcase
        end
    end

    // Hold phase, counters and the payload store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            type_reg   <= 8'd0;
            remain_reg <= 8'd0;
            index_reg  <= 8'd0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                store_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            remain_reg <= remain_next;
            index_reg  <= index_next;
            // drop bytes past the end of the store
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                if (store_wr && index_reg == 8'(i))
                begin
                    store_reg[i] <= byte_data;
                end
            end
        end
    end

    // Positions past the store read as zero
    for (genvar g = 0; g < DECODE_BYTES; g++)
    begin : g_pad
        if (g < PAYLOAD_BYTES)
        begin : g_have
            assign frame_byte[g] = store_reg[g];
        end
        else
        begin : g_zero
            assign frame_byte[g] = 8'd0;
        end
    end

    // Build the big-endian job fields
    always_comb
    begin
        job.kind = (type_reg == TYPE_ENV) ? KIND_ENV : KIND_LIGHT;
        if (type_reg == TYPE_ENV)
        begin
            job.word = {frame_byte[2], frame_byte[3], frame_byte[4], frame_byte[5]};
        end
        else
        begin
            job.word = {frame_byte[0], frame_byte[1], frame_byte[2], frame_byte[3]};
        end
        job.temp = {frame_byte[0], frame_byte[1]};
        job.hum  = {frame_byte[6], frame_byte[7]};
        job.alt  = {frame_byte[8], frame_byte[9]};
    end

    `SFDD_ASSERT_IMPLY(a_push_on_check, job_push, phase_reg == PH_CHECK && accept, "push outside checksum word")
    `SFDD_ASSERT_IMPLY(a_push_has_room, job_push, !qstat.full, "push into full queue")

endmodule

@@ src/sfdd_queue.sv @@
module sfdd_queue
    import sfdd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    input  logic   pop,
    output job_t   head_job,
    output qstat_t qstat
);

`include "sensor_frame_deframer_decoder_defines.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_job    = mem[rd_ptr_reg];

    // Write entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `SFDD_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

@@ src/sfdd_back.sv @@
module sfdd_back
    import sfdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  qstat_t      qstat,
    input  job_t        head_job,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [87:0] out_data
);

`include "sensor_frame_deframer_decoder_defines.svh"

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_MULT = 2'd1,
        B_FIN  = 2'd2
    } bstate_t;

    bstate_t             state_reg;
    logic [1:0]          cnt_reg;
    job_t                job_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SMALL_W-1:0]  temp_q_reg, hum_q_reg;
    logic [PRESS_W-1:0]  press_q_reg;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [LUX_W-1:0]    out_lux_reg;
    logic [SMALL_W-1:0]  out_temp_reg, out_hum_reg, out_alt_reg;
    logic [PRESS_W-1:0]  out_press_reg;
    logic [RAW_W-1:0]    mul_op;
    logic [PROD_W-1:0]   mul_prod;
    logic [PRESS_W-1:0]  quot;
    logic                out_load;

    // Quotient of the product now held
    assign quot     = prod_reg[PROD_W-1:DIV100_SHIFT];
    assign job_pop  = (state_reg == B_IDLE) && !qstat.empty;
    assign out_load = (state_reg == B_FIN) && (!out_valid_reg || out_ready);

    // Pick the operand for the shared multiplier
    always_comb
    begin
        if (state_reg == B_IDLE)
        begin
            mul_op = RAW_W'(head_job.temp);
        end
        else
        begin
            case (cnt_reg)
                2'd1:    mul_op = job_reg.word;
                2'd2:    mul_op = RAW_W'(job_reg.hum);
                2'd3:    mul_op = RAW_W'(job_reg.alt);
                default: mul_op = RAW_W'(job_reg.temp);
            endcase
        end
    end

    assign mul_prod = PROD_W'(mul_op) * PROD_W'(DIV100_MAGIC);

    // Sequence the divisions and hold the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= 2'd0;
            job_reg       <= '0;
            prod_reg      <= '0;
            temp_q_reg    <= '0;
            press_q_reg   <= '0;
            hum_q_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_LIGHT;
            out_lux_reg   <= '0;
            out_temp_reg  <= '0;
            out_press_reg <= '0;
            out_hum_reg   <= '0;
            out_alt_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_pop)
                    begin
                        job_reg  <= head_job;
                        prod_reg <= mul_prod;
                        cnt_reg  <= 2'd1;
                        state_reg <= (head_job.kind == KIND_ENV) ? B_MULT : B_FIN;
                    end
                end
                B_MULT:
                begin
                    prod_reg <= mul_prod;
                    case (cnt_reg)
                        2'd1:    temp_q_reg  <= quot[SMALL_W-1:0];
                        2'd2:    press_q_reg <= quot;
                        default: hum_q_reg   <= quot[SMALL_W-1:0];
                    endcase
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= job_reg.kind;
                        if (job_reg.kind == KIND_ENV)
                        begin
                            out_lux_reg   <= '0;
                            out_temp_reg  <= temp_q_reg;
                            out_press_reg <= press_q_reg;
                            out_hum_reg   <= hum_q_reg;
                            out_alt_reg   <= quot[SMALL_W-1:0];
                        end
                        else
                        begin
                            out_lux_reg   <= job_reg.word;
                            out_temp_reg  <= '0;
                            out_press_reg <= '0;
                            out_hum_reg   <= '0;
                            out_alt_reg   <= '0;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_data  = {out_alt_reg, out_hum_reg, out_press_reg, out_temp_reg, out_lux_reg};

    `SFDD_ASSERT_IMPLY(a_pop_nonempty, job_pop, !qstat.empty, "pop from empty queue")
    `SFDD_ASSERT_NEXT(a_load_shows, out_load, out_valid_reg, "loaded word not shown")

endmodule
